>>> rtl/escaped_frame_capture_top_assert.svh
// assertion macros for the escaped frame capture checker
// no dependencies; included by the checker file
`ifndef ESCAPED_FRAME_CAPTURE_TOP_ASSERT_SVH
`define ESCAPED_FRAME_CAPTURE_TOP_ASSERT_SVH

// same-cycle implication
`define EFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/efc_pkg.sv
// shared widths, register indexes and the close control struct for the frame capture
// no dependencies
`default_nettype none

package efc_pkg;

   localparam int DATA_W          = 8;
   localparam int POS_W           = 6;
   localparam int RSP_DATA_W      = 16;
   localparam int RSP_PAD_W       = RSP_DATA_W - DATA_W - POS_W;
   localparam int CSR_IDX_W       = 2;
   localparam int FRAME_DEPTH_DEF = 64;

   localparam logic [CSR_IDX_W-1:0] REG_START  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ESCAPE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_END    = 2'd2;

   localparam logic [DATA_W-1:0] START_RST  = 8'd2;
   localparam logic [DATA_W-1:0] ESCAPE_RST = 8'd27;
   localparam logic [DATA_W-1:0] END_RST    = 8'd3;

   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] length;
   } close_type;

endpackage

`default_nettype wire

>>> rtl/efc_store.sv
// frame byte store: one write port, one read port with registered read data
// depends on efc_pkg
`default_nettype none

module efc_store #(
   parameter int  FRAME_DEPTH = efc_pkg::FRAME_DEPTH_DEF,
   localparam int ADDR_W      = $clog2(FRAME_DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [efc_pkg::DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output logic      [efc_pkg::DATA_W-1:0] rd_data
);
   import efc_pkg::*;

   logic [DATA_W-1:0] mem [FRAME_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/efc_parser.sv
// byte parser: control registers, frame state and store write decisions
// depends on efc_pkg
`default_nettype none

module efc_parser #(
   parameter int  FRAME_DEPTH = efc_pkg::FRAME_DEPTH_DEF,
   localparam int ADDR_W      = $clog2(FRAME_DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [efc_pkg::DATA_W-1:0]    req_tdata,
   input  wire logic                          csr_we,
   input  wire logic [efc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [efc_pkg::DATA_W-1:0]    csr_wdata,
   input  wire logic                          emit_done,
   output efc_pkg::close_type                 close,
   output logic                               mem_we,
   output logic      [ADDR_W-1:0]             mem_addr,
   output logic      [efc_pkg::DATA_W-1:0]    mem_data
);
   import efc_pkg::*;

   localparam logic ST_ACCEPT = 1'b0;
   localparam logic ST_EMIT   = 1'b1;
   localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(FRAME_DEPTH - 1);

   logic [DATA_W-1:0] start_ff, escape_ff, end_ff;
   logic              state_ff, state_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic              in_frame_ff, in_frame_in;
   logic              esc_ff, esc_in;
   logic              end_seen_ff, end_seen_in;
   logic              hold_ff, hold_in;
   logic [DATA_W-1:0] hold_byte_ff, hold_byte_in;
   logic [ADDR_W-1:0] nwp;
   logic              accept;
   logic              is_start, is_escape, is_end;

   assign req_tready = (state_ff == ST_ACCEPT);
   assign accept     = req_tvalid && req_tready;
   assign nwp        = wp_ff + 1'b1;
   assign is_start   = (req_tdata == start_ff);
   assign is_escape  = (req_tdata == escape_ff);
   assign is_end     = (req_tdata == end_ff);

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      in_frame_in  = in_frame_ff;
      esc_in       = esc_ff;
      end_seen_in  = end_seen_ff;
      hold_in      = hold_ff;
      hold_byte_in = hold_byte_ff;
      mem_we       = 1'b0;
      mem_addr     = '0;
      mem_data     = req_tdata;
      close        = '0;
      if (state_ff == ST_EMIT) begin
         if (emit_done) begin
            state_in = ST_ACCEPT;
            if (hold_ff) begin
               // restart byte held back until the last word of the frame was sent
               mem_we   = 1'b1;
               mem_addr = '0;
               mem_data = hold_byte_ff;
               hold_in  = 1'b0;
            end
         end
      end else if (accept) begin
         if (!in_frame_ff) begin
            if (is_start) begin
               in_frame_in = 1'b1;
               end_seen_in = 1'b0;
               mem_we      = 1'b1;
               mem_addr    = wp_ff;
            end
         end else if (!end_seen_ff && !esc_ff && is_escape) begin
            esc_in = 1'b1;
         end else if (wp_ff == LAST_POS) begin
            // overflow: drop frame, treat byte as idle
            wp_in       = '0;
            esc_in      = 1'b0;
            end_seen_in = 1'b0;
            in_frame_in = is_start;
            if (is_start) begin
               mem_we   = 1'b1;
               mem_addr = '0;
            end
         end else if (esc_ff) begin
            esc_in   = 1'b0;
            wp_in    = nwp;
            mem_we   = 1'b1;
            mem_addr = nwp;
         end else if (is_start && !end_seen_ff) begin
            wp_in    = '0;
            mem_we   = 1'b1;
            mem_addr = '0;
         end else if (!end_seen_ff && is_end) begin
            end_seen_in = 1'b1;
            wp_in       = nwp;
            mem_we      = 1'b1;
            mem_addr    = nwp;
         end else if (end_seen_ff && !is_end) begin
            // close frame, then treat byte as idle
            close.valid  = 1'b1;
            close.length = POS_W'(nwp);
            state_in     = ST_EMIT;
            wp_in        = '0;
            end_seen_in  = 1'b0;
            in_frame_in  = is_start;
            hold_in      = is_start;
            hold_byte_in = req_tdata;
         end else begin
            wp_in    = nwp;
            mem_we   = 1'b1;
            mem_addr = nwp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= START_RST;
         escape_ff   <= ESCAPE_RST;
         end_ff      <= END_RST;
         state_ff    <= ST_ACCEPT;
         wp_ff       <= '0;
         in_frame_ff <= 1'b0;
         esc_ff      <= 1'b0;
         end_seen_ff <= 1'b0;
         hold_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_START:  start_ff  <= csr_wdata;
               REG_ESCAPE: escape_ff <= csr_wdata;
               REG_END:    end_ff    <= csr_wdata;
               default:    ;
            endcase
         end
         state_ff    <= state_in;
         wp_ff       <= wp_in;
         in_frame_ff <= in_frame_in;
         esc_ff      <= esc_in;
         end_seen_ff <= end_seen_in;
         hold_ff     <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_byte_ff <= hold_byte_in;
   end

endmodule

`default_nettype wire

>>> rtl/efc_emit.sv
// frame emitter: walks the store from position zero and drives the result stream
// depends on efc_pkg
`default_nettype none

module efc_emit #(
   parameter int  FRAME_DEPTH = efc_pkg::FRAME_DEPTH_DEF,
   localparam int ADDR_W      = $clog2(FRAME_DEPTH)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire efc_pkg::close_type             close,
   input  wire logic [efc_pkg::DATA_W-1:0]     rd_data,
   output logic      [ADDR_W-1:0]              rd_addr,
   output logic                                emit_done,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [efc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                                rsp_tlast
);
   import efc_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] len_ff, len_in;
   logic             valid_ff, valid_in;
   logic             take, last;

   assign take      = valid_ff && rsp_tready;
   assign last      = (pos_ff == (len_ff - 1'b1));
   assign emit_done = take && last;

   always_comb begin
      pos_in   = pos_ff;
      len_in   = len_ff;
      valid_in = valid_ff;
      if (close.valid) begin
         pos_in   = '0;
         len_in   = close.length;
         valid_in = 1'b1;
      end else if (take) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // read address follows the word shown next cycle, so a stall re-reads it
   assign rd_addr = pos_in[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
         len_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, pos_ff, rd_data};
   assign rsp_tlast  = last;

endmodule

`default_nettype wire

>>> rtl/escaped_frame_capture_top.sv
// Escaped frame capture, top level.
// Depends on efc_pkg, efc_parser, efc_store and efc_emit.
//
// Request channel: one received link byte per word. A byte is accepted every
// cycle while no frame is being sent. Result channel: a completed frame, start
// byte at position zero, one stored byte per word with its position, tlast on
// the final byte. When a byte closes a frame, the first word appears in the
// cycle after that byte is accepted and one word follows per cycle while the
// receiver is ready; the request channel is held until the last word of the
// frame is taken. The closing byte itself is handled as a fresh idle byte in
// the same cycle. When the receiver stalls, the current word holds and no
// request is taken. Overflowing frames are dropped silently.
// Synchronous reset restores the default start, escape and end codes and the
// idle state; the store is not cleared, as only written entries are read.
// Configuration writes take effect at the clock edge of csr_we.
`default_nettype none

module escaped_frame_capture_top #(
   parameter int FRAME_DEPTH = efc_pkg::FRAME_DEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [efc_pkg::DATA_W-1:0]     req_tdata,   // rx_byte
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [efc_pkg::RSP_DATA_W-1:0] rsp_tdata,   // frame_byte, byte_position
   output logic                                rsp_tlast,   // frame_last
   input  wire logic                           csr_we,
   input  wire logic [efc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [efc_pkg::DATA_W-1:0]     csr_wdata
);
   import efc_pkg::*;

   localparam int ADDR_W = $clog2(FRAME_DEPTH);

   close_type         close;
   logic              emit_done;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [DATA_W-1:0] mem_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;

   efc_parser #(.FRAME_DEPTH(FRAME_DEPTH)) u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .emit_done  (emit_done),
      .close      (close),
      .mem_we     (mem_we),
      .mem_addr   (mem_addr),
      .mem_data   (mem_data)
   );

   efc_store #(.FRAME_DEPTH(FRAME_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_addr),
      .wr_data (mem_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   efc_emit #(.FRAME_DEPTH(FRAME_DEPTH)) u_emit (
      .clock      (clock),
      .reset      (reset),
      .close      (close),
      .rd_data    (rd_data),
      .rd_addr    (rd_addr),
      .emit_done  (emit_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> rtl/efc_checker.sv
// port-level checks of the escaped frame capture, bound to the top level
// depends on efc_pkg and escaped_frame_capture_top_assert.svh
`default_nettype none

`include "escaped_frame_capture_top_assert.svh"

module efc_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [efc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                           rsp_tlast
);
   import efc_pkg::*;

   logic [POS_W-1:0] pos;
   logic             take;

   assign pos  = rsp_tdata[DATA_W +: POS_W];
   assign take = rsp_tvalid && rsp_tready;

   `EFC_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result word changed under stall")
   `EFC_ASSERT_NOW(a_no_accept_while_sending, clock, reset, rsp_tvalid, !req_tready, "byte accepted while a frame is sent")
   `EFC_ASSERT_NEXT(a_position_steps, clock, reset, take && !rsp_tlast, rsp_tvalid && (pos == $past(pos) + 6'd1), "frame position did not advance by one")
   `EFC_ASSERT_NEXT(a_gap_after_last, clock, reset, take && rsp_tlast, !rsp_tvalid, "result word right after frame end")
   `EFC_ASSERT_NOW(a_frame_length, clock, reset, rsp_tvalid && rsp_tlast, pos != 6'd0, "frame shorter than two bytes")

endmodule

bind escaped_frame_capture_top efc_checker u_efc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for escaped_frame_capture_top: link bytes in, captured frames out
// depends on efc_pkg and the frame capture rtl; predicts every frame word in place

module tb;
   import efc_pkg::*;

   localparam int FRAME_DEPTH   = 64;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 2000;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [POS_W-1:0]  pos;
      logic              last;
   } frame_word_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata  = '0;     // rx_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;           // frame_byte, byte_position
   logic                  rsp_tlast;           // frame_last
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = REG_START;
   logic [DATA_W-1:0]     csr_wdata  = '0;

   // predicted block state
   logic [DATA_W-1:0] start_code  = START_RST;
   logic [DATA_W-1:0] escape_code = ESCAPE_RST;
   logic [DATA_W-1:0] end_code    = END_RST;
   logic [DATA_W-1:0] frame_store [FRAME_DEPTH];
   int                write_pos      = 0;
   bit                in_frame       = 1'b0;
   bit                escape_pending = 1'b0;
   bit                end_seen       = 1'b0;

   frame_word_type frame_words [$];
   int             error_count   = 0;
   int             bytes_sent    = 0;
   bit             sender_busy   = 1'b1;
   bit             receiver_busy = 1'b1;

   escaped_frame_capture_top #(.FRAME_DEPTH(FRAME_DEPTH)) i_dut (
      .clock,
      .reset,
      .req_tvalid,
      .req_tready,
      .req_tdata,
      .rsp_tvalid,
      .rsp_tready,
      .rsp_tdata,
      .rsp_tlast,
      .csr_we,
      .csr_index,
      .csr_wdata
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // returns 1 when the byte has to be parsed again from idle
   function automatic bit parse_byte(input logic [DATA_W-1:0] b);
      frame_word_type w;
      if (!in_frame) begin
         if (b == start_code) begin
            in_frame = 1'b1;
            end_seen = 1'b0;
            frame_store[write_pos] = b;
         end
         return 1'b0;
      end
      if (!end_seen && !escape_pending && b == escape_code) begin
         escape_pending = 1'b1;
         return 1'b0;
      end
      if (write_pos + 1 >= FRAME_DEPTH) begin
         write_pos      = 0;
         in_frame       = 1'b0;
         end_seen       = 1'b0;
         escape_pending = 1'b0;
         return 1'b1;
      end
      write_pos++;
      if (escape_pending) begin
         escape_pending = 1'b0;
         frame_store[write_pos] = b;
         return 1'b0;
      end
      if (b == start_code && !end_seen) begin
         write_pos      = 0;
         frame_store[0] = b;
         return 1'b0;
      end
      frame_store[write_pos] = b;
      if (!end_seen && b == end_code) begin
         end_seen = 1'b1;
         return 1'b0;
      end
      if (end_seen && b != end_code) begin
         for (int k = 0; k < write_pos; k++) begin
            w.data = frame_store[k];
            w.pos  = POS_W'(k);
            w.last = (k + 1 == write_pos);
            frame_words.push_back(w);
         end
         write_pos = 0;
         in_frame  = 1'b0;
         end_seen  = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void predict_byte(input logic [DATA_W-1:0] b);
      if (parse_byte(b))
         void'(parse_byte(b));
   endfunction

   function automatic logic [DATA_W-1:0] plain_byte();
      logic [DATA_W-1:0] b;
      do
         b = DATA_W'($urandom);
      while (b == start_code || b == escape_code || b == end_code);
      return b;
   endfunction

   task automatic report_error(input string what);
      error_count++;
      $display("error at %0t ns: %s", $time, what);
   endtask

   task automatic check_word(input logic [RSP_DATA_W-1:0] tdata, input logic tlast);
      frame_word_type want;
      if (frame_words.size() == 0) begin
         report_error($sformatf("unexpected word %h last %b", tdata, tlast));
         return;
      end
      want = frame_words.pop_front();
      if (tdata[DATA_W-1:0] !== want.data)
         report_error($sformatf("frame byte %h, expected %h at position %0d",
                                tdata[DATA_W-1:0], want.data, want.pos));
      if (tdata[DATA_W +: POS_W] !== want.pos)
         report_error($sformatf("byte position %0d, expected %0d",
                                tdata[DATA_W +: POS_W], want.pos));
      if (tlast !== want.last)
         report_error($sformatf("last %b, expected %b at position %0d",
                                tlast, want.last, want.pos));
      if (tdata[RSP_DATA_W-1 -: RSP_PAD_W] !== '0)
         report_error($sformatf("pad bits %b not zero", tdata[RSP_DATA_W-1 -: RSP_PAD_W]));
   endtask

   // valid stays high after acceptance, dropping only for a random gap while the sender is busy
   task automatic send_byte(input logic [DATA_W-1:0] b);
      int gap;
      gap = sender_busy ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      predict_byte(b);
      bytes_sent++;
   endtask

   task automatic wait_settled();
      req_tvalid <= 1'b0;
      while (frame_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_codes(input logic [DATA_W-1:0] s, e, x);
      logic [DATA_W-1:0]    vals [3];
      logic [CSR_IDX_W-1:0] idx  [3];
      vals = '{s, e, x};
      idx  = '{REG_START, REG_ESCAPE, REG_END};
      for (int i = 0; i < 3; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we      <= 1'b0;
      start_code  = s;
      escape_code = e;
      end_code    = x;
   endtask

   // mostly well-formed frames with some noise, escapes, restarts and stray end bytes
   task automatic send_random_frame();
      int noise;
      int len;
      int pick;
      noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (noise) send_byte(DATA_W'($urandom));
      send_byte(start_code);
      pick = $urandom_range(0, 19);
      len  = (pick < 16) ? $urandom_range(0, 12) :
             (pick < 19) ? $urandom_range(13, 40) : $urandom_range(55, 66);
      repeat (len) begin
         pick = $urandom_range(0, 15);
         if (pick == 0) begin
            send_byte(escape_code);
            send_byte(DATA_W'($urandom));
         end else if (pick == 1) begin
            send_byte(start_code);
         end else if (pick == 2) begin
            send_byte(end_code);
         end else begin
            send_byte(DATA_W'($urandom));
         end
      end
      repeat ($urandom_range(1, 3)) send_byte(end_code);
      pick = $urandom_range(0, 7);
      if (pick < 2)
         send_byte(start_code);
      else if (pick == 2)
         send_byte(escape_code);
      else
         send_byte(plain_byte());
   endtask

   task automatic run_frames(input int count, input bit s_busy, input bit r_busy);
      int stop_at;
      sender_busy   = s_busy;
      receiver_busy = r_busy;
      stop_at       = bytes_sent + count;
      while (bytes_sent < stop_at)
         send_random_frame();
      wait_settled();
   endtask

   task automatic test_default_codes();
      logic [DATA_W-1:0] s;
      logic [DATA_W-1:0] e;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] seq [$];
      s = START_RST;
      e = ESCAPE_RST;
      x = END_RST;
      // idle noise, escaped codes, double end, restart, close on start, close on escape
      seq = '{8'h00, 8'hFF,
              s, 8'h00, 8'hFF, e, s, e, x, e, e, x, x, 8'h41,
              s, 8'h11, s, 8'h22, x, s,
              8'h33, x, e, 8'h00};
      foreach (seq[i])
         send_byte(seq[i]);
      wait_settled();
   endtask

   task automatic test_overflow();
      sender_busy   = 1'b0;
      receiver_busy = 1'b1;
      // longest frame that still fits
      send_byte(START_RST);
      repeat (61) send_byte(plain_byte());
      send_byte(END_RST);
      send_byte(plain_byte());
      // store fills with an escape pending, the next start byte opens a new frame
      send_byte(START_RST);
      repeat (63) send_byte(plain_byte());
      send_byte(ESCAPE_RST);
      send_byte(START_RST);
      send_byte(plain_byte());
      send_byte(END_RST);
      send_byte(plain_byte());
      // trailing end bytes run past the store
      send_byte(START_RST);
      repeat (61) send_byte(plain_byte());
      repeat (3) send_byte(END_RST);
      send_byte(plain_byte());
      wait_settled();
   endtask

   task automatic test_code_extremes();
      set_codes(8'h00, 8'hFF, 8'h80);
      run_frames(5, 1'b1, 1'b1);
      set_codes(8'hFF, 8'h00, 8'h01);
      run_frames(5, 1'b0, 1'b0);
   endtask

   task automatic test_equal_codes();
      logic [DATA_W-1:0] v;
      v = DATA_W'($urandom);
      set_codes(v, v, v + 8'd1);
      run_frames(5, 1'b1, 1'b1);
      set_codes(v, v + 8'd1, v + 8'd1);
      run_frames(5, 1'b1, 1'b0);
      set_codes(v, v + 8'd1, v);
      run_frames(5, 1'b0, 1'b1);
      set_codes(v, v, v);
      run_frames(5, 1'b1, 1'b1);
   endtask

   task automatic test_random_codes();
      logic [DATA_W-1:0] s;
      logic [DATA_W-1:0] e;
      logic [DATA_W-1:0] x;
      repeat (2) begin
         do begin
            s = DATA_W'($urandom);
            e = DATA_W'($urandom);
            x = DATA_W'($urandom);
         end while (s == e || s == x || e == x);
         set_codes(s, e, x);
         run_frames(5, 1'($urandom), 1'($urandom));
      end
   endtask

   initial begin : word_checker
      int stall;
      @(posedge clock iff !reset);
      forever begin
         stall = receiver_busy ? $urandom_range(0, 10) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         check_word(rsp_tdata, rsp_tlast);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_default_codes();
      test_overflow();
      test_code_extremes();
      test_equal_codes();
      test_random_codes();
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
